FILE: sv/itoa_pkg.sv
// itoa_pkg: shared types, constants and the digit glyph function
// used by the controller, the datapath and the top level of the converter
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 6;
    localparam int RADIX_W     = 6;
    localparam int FLAGS_W     = 5;
    localparam int NUMBER_W    = 32;
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = 5;
    localparam int CNT_W       = 6;
    localparam int BITS_PER_CYCLE = 4;

    localparam logic [RADIX_W-1:0] MIN_RADIX     = 6'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX     = 6'd36;
    localparam logic [RADIX_W-1:0] DEFAULT_RADIX = 6'd10;
    localparam logic [RADIX_W-1:0] BINARY_RADIX  = 6'd2;

    localparam int FLAG_SIGNED  = 0;
    localparam int FLAG_PLUS    = 1;
    localparam int FLAG_MIN_TWO = 2;
    localparam int FLAG_GROUPED = 3;
    localparam int FLAG_UPPER   = 4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER = 7'h61;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SIGN,
        CMD_DIV,
        CMD_PAD,
        CMD_DIGIT,
        CMD_SPACE
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic pad_left;
        logic last_digit;
        logic need_space;
    } dp_status_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d,
                                                input logic upper);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d > 6'd9)
        begin
            glyph = dx - 7'd10 + (upper ? CH_UPPER : CH_LOWER);
        end
        else
        begin
            glyph = dx + CH_ZERO;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/itoa_ctrl.sv
// itoa_ctrl: sequencing state machine of the converter
// depends on itoa_pkg for the command and status types
`timescale 1ns / 1ps
`default_nettype none

module itoa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  itoa_pkg::dp_status_t    status,
    output itoa_pkg::dp_cmd_t       cmd,
    output logic                    busy
);
    import itoa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_DIV,
        S_PAD,
        S_DIGIT,
        S_SPACE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_SIGN;
                    busy_next  = 1'b1;
                end
            end
            S_SIGN:
            begin
                cmd        = CMD_SIGN;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd = CMD_DIV;
                if (status.div_done)
                begin
                    state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                if (status.pad_left)
                begin
                    cmd = CMD_PAD;
                end
                else
                begin
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                cmd = CMD_DIGIT;
                if (status.last_digit)
                begin
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                end
                else if (status.need_space)
                begin
                    state_next = S_SPACE;
                end
            end
            S_SPACE:
            begin
                cmd        = CMD_SPACE;
                state_next = S_DIGIT;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

    a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy out of step with state");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIGIT && status.last_digit) |=> (state_reg == S_IDLE))
        else $error("final digit did not end the item");

endmodule

`default_nettype wire

FILE: sv/itoa_datapath.sv
// itoa_datapath: radix divider, digit store and character output register
// depends on itoa_pkg for commands, status, constants and glyph()
`timescale 1ns / 1ps
`default_nettype none

module itoa_datapath #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [itoa_pkg::NUMBER_W-1:0] number,
    input  wire logic [itoa_pkg::RADIX_W-1:0]  radix,
    input  wire logic [itoa_pkg::FLAGS_W-1:0]  format_flags,
    input  itoa_pkg::dp_cmd_t                  cmd,
    output itoa_pkg::dp_status_t               status,
    output logic                               char_valid,
    output logic [itoa_pkg::CHAR_W-1:0]        text_char,
    output logic                               last_char
);
    import itoa_pkg::*;

    localparam int DIV_W  = ((VALUE_BITS + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE)
                            * BITS_PER_CYCLE;
    localparam int STEPS  = DIV_W / BITS_PER_CYCLE;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [DIGIT_W-1:0] digit_store [STORE_DEPTH];

    logic [RADIX_W-1:0] base_reg;
    logic               upper_reg, grouped_reg, small_reg, neg_reg, plus_reg;
    logic [DIV_W-1:0]   quot_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [1:0]         pad_reg;
    logic [1:0]         phase_reg;
    logic               char_valid_reg, last_char_reg;
    logic [CHAR_W-1:0]  text_char_reg;

    logic [VALUE_BITS+NUMBER_W-1:0] ext;
    logic [VALUE_BITS-1:0]          raw, mag;
    logic                           neg_in, small_in;
    logic [RADIX_W-1:0]             base_in;

    logic [DIV_W-1:0]   div_q;
    logic [DIGIT_W-1:0] div_r;
    logic               div_last, more;
    logic [CNT_W-1:0]   cnt_inc;
    logic [1:0]         pad_calc, group_max;
    logic [DIGIT_W-1:0] rd_digit;

    // operand capture
    always_comb
    begin
        ext      = {{VALUE_BITS{1'b0}}, number};
        raw      = ext[VALUE_BITS-1:0];
        neg_in   = format_flags[FLAG_SIGNED] && raw[VALUE_BITS-1];
        mag      = neg_in ? (~raw + VALUE_BITS'(1)) : raw;
        base_in  = (radix < MIN_RADIX || radix > MAX_RADIX) ? DEFAULT_RADIX : radix;
        small_in = format_flags[FLAG_MIN_TWO] && (mag < VALUE_BITS'(base_in));
    end

    // restoring division, BITS_PER_CYCLE quotient bits per cycle
    always_comb
    begin
        logic [DIGIT_W:0]   r7;
        logic [DIGIT_W-1:0] r;
        logic [DIV_W-1:0]   q;
        r = rem_reg;
        q = quot_reg;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            r7 = {r, q[DIV_W-1]};
            q  = {q[DIV_W-2:0], 1'b0};
            if (r7 >= {1'b0, base_reg})
            begin
                r7   = r7 - {1'b0, base_reg};
                q[0] = 1'b1;
            end
            r = r7[DIGIT_W-1:0];
        end
        div_q = q;
        div_r = r;
    end

    always_comb
    begin
        div_last  = (step_reg == STEP_W'(STEPS - 1));
        cnt_inc   = cnt_reg + CNT_W'(1);
        more      = (div_q != '0) && (cnt_reg != CNT_W'(STORE_DEPTH - 1));
        group_max = (base_reg == BINARY_RADIX) ? 2'd3 : 2'd2;
        if (small_reg)
        begin
            pad_calc = 2'd1;
        end
        else if (base_reg == BINARY_RADIX || grouped_reg)
        begin
            pad_calc = ~cnt_inc[1:0] + 2'd1;
        end
        else
        begin
            pad_calc = 2'd0;
        end
        rd_digit = digit_store[STORE_AW'(cnt_reg - CNT_W'(1))];

        status.div_done   = div_last && !more;
        status.pad_left   = (pad_reg != 2'd0);
        status.last_digit = (cnt_reg == CNT_W'(1));
        status.need_space = grouped_reg && (cnt_reg > CNT_W'(1)) && (phase_reg == 2'd0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_DIV && div_last)
        begin
            digit_store[cnt_reg[STORE_AW-1:0]] <= div_r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD)
        begin
            upper_reg   <= format_flags[FLAG_UPPER];
            grouped_reg <= format_flags[FLAG_GROUPED];
            small_reg   <= small_in;
            neg_reg     <= neg_in;
            plus_reg    <= format_flags[FLAG_SIGNED] && format_flags[FLAG_PLUS] && !neg_in;
        end
        case (cmd)
            CMD_LOAD:  quot_reg <= DIV_W'(mag);
            CMD_DIV:   quot_reg <= div_q;
            default:   quot_reg <= quot_reg;
        endcase
        case (cmd)
            CMD_SIGN:  text_char_reg <= neg_reg ? CH_MINUS : CH_PLUS;
            CMD_PAD:   text_char_reg <= CH_ZERO;
            CMD_DIGIT: text_char_reg <= glyph(rd_digit, upper_reg);
            CMD_SPACE: text_char_reg <= CH_SPACE;
            default:   text_char_reg <= text_char_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg       <= DEFAULT_RADIX;
            rem_reg        <= '0;
            step_reg       <= '0;
            cnt_reg        <= '0;
            pad_reg        <= '0;
            phase_reg      <= '0;
            char_valid_reg <= 1'b0;
            last_char_reg  <= 1'b0;
        end
        else
        begin
            char_valid_reg <= 1'b0;
            last_char_reg  <= 1'b0;
            case (cmd)
                CMD_LOAD:
                begin
                    base_reg  <= base_in;
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    cnt_reg   <= '0;
                    pad_reg   <= '0;
                    phase_reg <= '0;
                end
                CMD_SIGN:
                begin
                    char_valid_reg <= neg_reg || plus_reg;
                end
                CMD_DIV:
                begin
                    if (div_last)
                    begin
                        rem_reg  <= '0;
                        step_reg <= '0;
                        cnt_reg  <= cnt_inc;
                        if (more)
                        begin
                            phase_reg <= (phase_reg == group_max) ? 2'd0 : phase_reg + 2'd1;
                        end
                        else
                        begin
                            pad_reg <= pad_calc;
                        end
                    end
                    else
                    begin
                        rem_reg  <= div_r;
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                CMD_PAD:
                begin
                    char_valid_reg <= 1'b1;
                    pad_reg        <= pad_reg - 2'd1;
                end
                CMD_DIGIT:
                begin
                    char_valid_reg <= 1'b1;
                    last_char_reg  <= (cnt_reg == CNT_W'(1));
                    cnt_reg        <= cnt_reg - CNT_W'(1);
                    phase_reg      <= (phase_reg == 2'd0) ? group_max : phase_reg - 2'd1;
                end
                CMD_SPACE:
                begin
                    char_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign char_valid = char_valid_reg;
    assign text_char  = text_char_reg;
    assign last_char  = last_char_reg;

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_char_reg |-> char_valid_reg)
        else $error("last flag without a character");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(STORE_DEPTH))
        else $error("digit count beyond store depth");

    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < base_reg)
        else $error("partial remainder not below base");

endmodule

`default_nettype wire

FILE: sv/integer_to_text_any_base_core.sv
// integer_to_text_any_base_core: top level, value to ASCII text in base 2..36
// order of an item: optional sign, then the pad zeros once the division is done,
// then the digits, most significant first, with a space between groups if grouped
// a new item is accepted only while idle; start is ignored while busy
// busy drops the cycle the last character shows; rst_n clears control, store stays
// characters are strobed by char_valid for one cycle; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module integer_to_text_any_base_core #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [itoa_pkg::NUMBER_W-1:0] number,
    input  wire logic [itoa_pkg::RADIX_W-1:0]  radix,
    input  wire logic [itoa_pkg::FLAGS_W-1:0]  format_flags,
    output logic                               char_valid,
    output logic [itoa_pkg::CHAR_W-1:0]        text_char,
    output logic                               last_char
);
    import itoa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    itoa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    itoa_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .number       (number),
        .radix        (radix),
        .format_flags (format_flags),
        .cmd          (cmd),
        .status       (status),
        .char_valid   (char_valid),
        .text_char    (text_char),
        .last_char    (last_char)
    );

endmodule

`default_nettype wire
